// File: src/agkf_pkg.sv
// ----------------------------------------------------------------------------
// agkf_pkg: shared types and constants of the angle/gyro Kalman filter
// Fixed-point formats, register indexes, datapath operand codes and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package agkf_pkg;

  localparam int DW        = 32;
  localparam int FRAC      = 24;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * DW;
  localparam int SCL_W     = PROD_W - FRAC;
  localparam int NUM_W     = DW + FRAC;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE_COV = DW'(1) << FRAC;

  localparam logic [CFG_W-1:0] DT_RST = CFG_W'(167772);
  localparam logic [CFG_W-1:0] QA_RST = CFG_W'(16777);
  localparam logic [CFG_W-1:0] QB_RST = CFG_W'(50332);
  localparam logic [CFG_W-1:0] R_RST  = CFG_W'(8388608);

  localparam logic [CFG_IDX_W-1:0] REG_DT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QB = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R  = 2'd3;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ANGLE, SRC_BIAS, SRC_AA, SRC_AB, SRC_BA, SRC_BB, SRC_RATE,
    SRC_T, SRC_DP, SRC_S, SRC_K0, SRC_K1, SRC_Y, SRC_MEAS, SRC_GYRO,
    SRC_DT, SRC_QA, SRC_QB, SRC_R, SRC_PROD
  } src_t;

  typedef enum logic [3:0] {
    DST_ANGLE, DST_BIAS, DST_AA, DST_AB, DST_BA, DST_BB, DST_RATE,
    DST_T, DST_DP, DST_S, DST_Y
  } dst_t;

  typedef struct packed {
    logic capture;
    logic mul_en;
    src_t mul_a;
    src_t mul_b;
    logic alu_en;
    logic alu_sub;
    src_t alu_a;
    src_t alu_b;
    dst_t alu_dst;
    logic div_start;
    logic gain_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } sts_t;

  localparam cmd_t CMD_NOP = '{capture: 1'b0, mul_en: 1'b0, mul_a: SRC_ZERO,
                               mul_b: SRC_ZERO, alu_en: 1'b0, alu_sub: 1'b0,
                               alu_a: SRC_ZERO, alu_b: SRC_ZERO,
                               alu_dst: DST_T, div_start: 1'b0,
                               gain_load: 1'b0, out_load: 1'b0};

  function automatic cmd_t cmd_mul(src_t a, src_t b);
    cmd_t c;
    c = CMD_NOP;
    c.mul_en = 1'b1;
    c.mul_a  = a;
    c.mul_b  = b;
    return c;
  endfunction

  function automatic cmd_t cmd_alu(logic sub, src_t a, src_t b, dst_t d);
    cmd_t c;
    c = CMD_NOP;
    c.alu_en  = 1'b1;
    c.alu_sub = sub;
    c.alu_a   = a;
    c.alu_b   = b;
    c.alu_dst = d;
    return c;
  endfunction

endpackage

// File: src/agkf_ctrl.sv
// ----------------------------------------------------------------------------
// agkf_ctrl: sequencer of the Kalman filter update
// Steps the datapath through prediction, gain division and correction,
// at most one multiply or one saturating add per state.
// ----------------------------------------------------------------------------
module agkf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  agkf_pkg::sts_t sts,
  output agkf_pkg::cmd_t cmd
);
  import agkf_pkg::*;

  typedef enum logic [32:0] {
    ST_IDLE   = 33'd1 << 0,  ST_RATE   = 33'd1 << 1,  ST_M_DR   = 33'd1 << 2,
    ST_ANG1   = 33'd1 << 3,  ST_M_DB   = 33'd1 << 4,  ST_DP     = 33'd1 << 5,
    ST_T1     = 33'd1 << 6,  ST_T2     = 33'd1 << 7,  ST_T3     = 33'd1 << 8,
    ST_M_DT   = 33'd1 << 9,  ST_AA1    = 33'd1 << 10, ST_AB1    = 33'd1 << 11,
    ST_BA1    = 33'd1 << 12, ST_M_QB   = 33'd1 << 13, ST_BB1    = 33'd1 << 14,
    ST_S      = 33'd1 << 15, ST_DIVS   = 33'd1 << 16, ST_DIVW   = 33'd1 << 17,
    ST_GAIN   = 33'd1 << 18, ST_Y      = 33'd1 << 19, ST_M_K0Y  = 33'd1 << 20,
    ST_ANG2   = 33'd1 << 21, ST_M_K1Y  = 33'd1 << 22, ST_BIAS   = 33'd1 << 23,
    ST_M_K1AA = 33'd1 << 24, ST_BA2    = 33'd1 << 25, ST_M_K1AB = 33'd1 << 26,
    ST_BB2    = 33'd1 << 27, ST_M_K0AB = 33'd1 << 28, ST_AB2    = 33'd1 << 29,
    ST_M_K0AA = 33'd1 << 30, ST_AA2    = 33'd1 << 31, ST_DONE   = 33'd1 << 32
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = ST_RATE;
      end
      ST_RATE: begin
        cmd = cmd_alu(1'b1, SRC_GYRO, SRC_BIAS, DST_RATE);
        state_nxt = ST_M_DR;
      end
      ST_M_DR: begin
        cmd = cmd_mul(SRC_DT, SRC_RATE);
        state_nxt = ST_ANG1;
      end
      ST_ANG1: begin
        cmd = cmd_alu(1'b0, SRC_ANGLE, SRC_PROD, DST_ANGLE);
        state_nxt = ST_M_DB;
      end
      ST_M_DB: begin
        cmd = cmd_mul(SRC_DT, SRC_BB);
        state_nxt = ST_DP;
      end
      ST_DP: begin
        cmd = cmd_alu(1'b0, SRC_PROD, SRC_ZERO, DST_DP);
        state_nxt = ST_T1;
      end
      ST_T1: begin
        cmd = cmd_alu(1'b1, SRC_DP, SRC_AB, DST_T);
        state_nxt = ST_T2;
      end
      ST_T2: begin
        cmd = cmd_alu(1'b1, SRC_T, SRC_BA, DST_T);
        state_nxt = ST_T3;
      end
      ST_T3: begin
        cmd = cmd_alu(1'b0, SRC_T, SRC_QA, DST_T);
        state_nxt = ST_M_DT;
      end
      ST_M_DT: begin
        cmd = cmd_mul(SRC_DT, SRC_T);
        state_nxt = ST_AA1;
      end
      ST_AA1: begin
        cmd = cmd_alu(1'b0, SRC_AA, SRC_PROD, DST_AA);
        state_nxt = ST_AB1;
      end
      ST_AB1: begin
        cmd = cmd_alu(1'b1, SRC_AB, SRC_DP, DST_AB);
        state_nxt = ST_BA1;
      end
      ST_BA1: begin
        cmd = cmd_alu(1'b1, SRC_BA, SRC_DP, DST_BA);
        state_nxt = ST_M_QB;
      end
      ST_M_QB: begin
        cmd = cmd_mul(SRC_QB, SRC_DT);
        state_nxt = ST_BB1;
      end
      ST_BB1: begin
        cmd = cmd_alu(1'b0, SRC_BB, SRC_PROD, DST_BB);
        state_nxt = ST_S;
      end
      ST_S: begin
        cmd = cmd_alu(1'b0, SRC_AA, SRC_R, DST_S);
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (!sts.div_busy) state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain_load = 1'b1;
        state_nxt = ST_Y;
      end
      ST_Y: begin
        cmd = cmd_alu(1'b1, SRC_MEAS, SRC_ANGLE, DST_Y);
        state_nxt = ST_M_K0Y;
      end
      ST_M_K0Y: begin
        cmd = cmd_mul(SRC_K0, SRC_Y);
        state_nxt = ST_ANG2;
      end
      ST_ANG2: begin
        cmd = cmd_alu(1'b0, SRC_ANGLE, SRC_PROD, DST_ANGLE);
        state_nxt = ST_M_K1Y;
      end
      ST_M_K1Y: begin
        cmd = cmd_mul(SRC_K1, SRC_Y);
        state_nxt = ST_BIAS;
      end
      ST_BIAS: begin
        cmd = cmd_alu(1'b0, SRC_BIAS, SRC_PROD, DST_BIAS);
        state_nxt = ST_M_K1AA;
      end
      ST_M_K1AA: begin
        cmd = cmd_mul(SRC_K1, SRC_AA);
        state_nxt = ST_BA2;
      end
      ST_BA2: begin
        cmd = cmd_alu(1'b1, SRC_BA, SRC_PROD, DST_BA);
        state_nxt = ST_M_K1AB;
      end
      ST_M_K1AB: begin
        cmd = cmd_mul(SRC_K1, SRC_AB);
        state_nxt = ST_BB2;
      end
      ST_BB2: begin
        cmd = cmd_alu(1'b1, SRC_BB, SRC_PROD, DST_BB);
        state_nxt = ST_M_K0AB;
      end
      ST_M_K0AB: begin
        cmd = cmd_mul(SRC_K0, SRC_AB);
        state_nxt = ST_AB2;
      end
      ST_AB2: begin
        cmd = cmd_alu(1'b1, SRC_AB, SRC_PROD, DST_AB);
        state_nxt = ST_M_K0AA;
      end
      ST_M_K0AA: begin
        cmd = cmd_mul(SRC_K0, SRC_AA);
        state_nxt = ST_AA2;
      end
      ST_AA2: begin
        cmd = cmd_alu(1'b1, SRC_AA, SRC_PROD, DST_AA);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_RATE))
    else $error("accepted transaction did not start the update");
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVW && !sts.div_busy) |=> (state_r == ST_GAIN))
    else $error("gain load skipped after division");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending transaction");
`endif

endmodule

// File: src/agkf_dp.sv
// ----------------------------------------------------------------------------
// agkf_dp: datapath of the Kalman filter
// Filter state, configuration registers, one shared saturating multiplier,
// one saturating adder, a pair of bit-serial dividers and the result register.
// ----------------------------------------------------------------------------
module agkf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [agkf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [agkf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [2*agkf_pkg::DW-1:0]      in_tdata,
  input  agkf_pkg::cmd_t                 cmd,
  output agkf_pkg::sts_t                 sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [3*agkf_pkg::DW-1:0]      out_tdata
);
  import agkf_pkg::*;

  logic signed [DW-1:0] angle_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [DW-1:0] rate_r, t_r, dp_r, s_r, k0_r, k1_r, y_r, meas_r, gyro_r;
  logic [CFG_W-1:0] dt_r, qa_r, qb_r, rn_r;
  logic [PROD_W-1:0] prod_mag_r;
  logic              prod_neg_r;
  logic signed [DW-1:0] prod_val;

  logic [NUM_W-1:0]     num0_r, num1_r, q0_r, q1_r;
  logic [DW-1:0]        rem0_r, rem1_r, den_r;
  logic                 neg0_r, neg1_r, zden_r, busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [DW-1:0] out_angle_r, out_bias_r, out_rate_r;
  logic          out_valid_r;

  function automatic logic signed [DW-1:0] rd(src_t s);
    logic signed [DW-1:0] v;
    case (s)
      SRC_ZERO:  v = '0;
      SRC_ANGLE: v = angle_r;
      SRC_BIAS:  v = bias_r;
      SRC_AA:    v = aa_r;
      SRC_AB:    v = ab_r;
      SRC_BA:    v = ba_r;
      SRC_BB:    v = bb_r;
      SRC_RATE:  v = rate_r;
      SRC_T:     v = t_r;
      SRC_DP:    v = dp_r;
      SRC_S:     v = s_r;
      SRC_K0:    v = k0_r;
      SRC_K1:    v = k1_r;
      SRC_Y:     v = y_r;
      SRC_MEAS:  v = meas_r;
      SRC_GYRO:  v = gyro_r;
      SRC_DT:    v = {1'b0, dt_r};
      SRC_QA:    v = {1'b0, qa_r};
      SRC_QB:    v = {1'b0, qb_r};
      SRC_R:     v = {1'b0, rn_r};
      SRC_PROD:  v = prod_val;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [DW-1:0] mag(logic signed [DW-1:0] a);
    return a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

  function automatic logic signed [DW-1:0] settle(logic neg, logic [NUM_W-1:0] m);
    logic signed [DW-1:0] v;
    if (neg) begin
      v = (m >= NUM_W'({1'b1, {(DW-1){1'b0}}})) ? VMIN : -$signed(DW'(m));
    end else begin
      v = (m > NUM_W'(VMAX)) ? VMAX : $signed(DW'(m));
    end
    return v;
  endfunction

  // Scaled product, saturated to the data range.
  logic [SCL_W-1:0] prod_scl;
  assign prod_scl = SCL_W'(prod_mag_r >> FRAC);
  always_comb begin
    if (prod_neg_r) begin
      prod_val = (prod_scl >= SCL_W'({1'b1, {(DW-1){1'b0}}})) ? VMIN
                 : -$signed(DW'(prod_scl));
    end else begin
      prod_val = (prod_scl > SCL_W'(VMAX)) ? VMAX : $signed(DW'(prod_scl));
    end
  end

  logic signed [DW-1:0] ma, mb, aa_op, ab_op, alu_res;
  logic signed [DW:0]   sum;
  assign ma    = rd(cmd.mul_a);
  assign mb    = rd(cmd.mul_b);
  assign aa_op = rd(cmd.alu_a);
  assign ab_op = rd(cmd.alu_b);
  assign sum   = cmd.alu_sub ? ({aa_op[DW-1], aa_op} - {ab_op[DW-1], ab_op})
                             : ({aa_op[DW-1], aa_op} + {ab_op[DW-1], ab_op});
  assign alu_res = (sum[DW] != sum[DW-1]) ? (sum[DW] ? VMIN : VMAX) : sum[DW-1:0];

  // One restoring step of each divider.
  logic [DW:0]   tr0, tr1;
  logic          ge0, ge1;
  logic [DW-1:0] rem0_nxt, rem1_nxt;
  assign tr0 = {rem0_r, num0_r[NUM_W-1]};
  assign tr1 = {rem1_r, num1_r[NUM_W-1]};
  assign ge0 = tr0 >= {1'b0, den_r};
  assign ge1 = tr1 >= {1'b0, den_r};
  assign rem0_nxt = ge0 ? DW'(tr0 - {1'b0, den_r}) : tr0[DW-1:0];
  assign rem1_nxt = ge1 ? DW'(tr1 - {1'b0, den_r}) : tr1[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r    <= DT_RST;
      qa_r    <= QA_RST;
      qb_r    <= QB_RST;
      rn_r    <= R_RST;
      angle_r <= '0;
      bias_r  <= '0;
      aa_r    <= ONE_COV;
      ab_r    <= '0;
      ba_r    <= '0;
      bb_r    <= ONE_COV;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DT:  dt_r <= cfg_wdata;
          REG_QA:  qa_r <= cfg_wdata;
          REG_QB:  qb_r <= cfg_wdata;
          REG_R:   rn_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.alu_en) begin
        case (cmd.alu_dst)
          DST_ANGLE: angle_r <= alu_res;
          DST_BIAS:  bias_r  <= alu_res;
          DST_AA:    aa_r    <= alu_res;
          DST_AB:    ab_r    <= alu_res;
          DST_BA:    ba_r    <= alu_res;
          DST_BB:    bb_r    <= alu_res;
          default: ;
        endcase
      end
      if (cmd.div_start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(NUM_W - 1)) busy_r <= 1'b0;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas_r <= $signed(in_tdata[DW-1:0]);
      gyro_r <= $signed(in_tdata[2*DW-1:DW]);
    end
    if (cmd.alu_en) begin
      case (cmd.alu_dst)
        DST_RATE: rate_r <= alu_res;
        DST_T:    t_r    <= alu_res;
        DST_DP:   dp_r   <= alu_res;
        DST_S:    s_r    <= alu_res;
        DST_Y:    y_r    <= alu_res;
        default: ;
      endcase
    end
    if (cmd.mul_en) begin
      prod_mag_r <= PROD_W'(mag(ma)) * PROD_W'(mag(mb));
      prod_neg_r <= ma[DW-1] ^ mb[DW-1];
    end
    if (cmd.div_start) begin
      num0_r <= NUM_W'(mag(aa_r)) << FRAC;
      num1_r <= NUM_W'(mag(ba_r)) << FRAC;
      den_r  <= mag(s_r);
      neg0_r <= aa_r[DW-1] ^ s_r[DW-1];
      neg1_r <= ba_r[DW-1] ^ s_r[DW-1];
      zden_r <= (s_r == '0);
      rem0_r <= '0;
      rem1_r <= '0;
      q0_r   <= '0;
      q1_r   <= '0;
    end else if (busy_r) begin
      num0_r <= num0_r << 1;
      num1_r <= num1_r << 1;
      rem0_r <= rem0_nxt;
      rem1_r <= rem1_nxt;
      q0_r   <= {q0_r[NUM_W-2:0], ge0};
      q1_r   <= {q1_r[NUM_W-2:0], ge1};
    end
    if (cmd.gain_load) begin
      k0_r <= zden_r ? '0 : settle(neg0_r, q0_r);
      k1_r <= zden_r ? '0 : settle(neg1_r, q1_r);
    end
    if (cmd.out_load) begin
      out_angle_r <= angle_r;
      out_bias_r  <= bias_r;
      out_rate_r  <= rate_r;
    end
  end

  assign sts.div_busy = busy_r;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_rate_r, out_bias_r, out_angle_r};

endmodule

// File: src/angle_gyro_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter: two-state tilt angle and gyro bias Kalman filter
// Fuses a measured angle with a gyro rate, one result per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one sample per transaction, the out_ stream one
//   estimate per sample, in order. The cfg_ port writes time step, angle
//   and bias process noise and measurement noise; write it only while idle.
//   From acceptance to out_tvalid each sample runs through sequencer steps
//   on the shared multiplier and adder and the gain division (a start step,
//   one bit-serial quotient step per numerator bit and the exit check).
//   A new sample is accepted in the idle cycle after the previous update has
//   been placed in the output register; updates of two samples never overlap.
//   When out_tready stays low the result is held in the output register; the
//   next sample is still accepted and processed, then waits at the last step
//   until the pending transaction completes.
//   Synchronous reset restores the default registers, zero angle and bias,
//   and unit diagonal covariance; no result is pending after reset.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [agkf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [agkf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [2*agkf_pkg::DW-1:0]      in_tdata,   // angle_meas, rate_meas
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [3*agkf_pkg::DW-1:0]      out_tdata   // angle_est, bias_est, rate_est
);
  import agkf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  agkf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  agkf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
